// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// types, sizes and codes of the sorted priority queue
// used by the cell, the top level and the checker
package spq_pkg;

	localparam int CAPACITY      = 8;
	localparam int ID_BITS       = 16;
	localparam int PRIORITY_BITS = 8;
	localparam int CNT_BITS      = $clog2(CAPACITY + 1);
	localparam int OCC_BITS      = 4;
	localparam int IN_DATA_BITS  = ((ID_BITS + PRIORITY_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((ID_BITS + PRIORITY_BITS + OCC_BITS + 7) / 8) * 8;

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_SERVE  = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic                     insert;
		logic                     serve;
		logic [ID_BITS-1:0]       id;
		logic [PRIORITY_BITS-1:0] prio;
	} cell_cmd_t;

	// position of one cell relative to the fill level
	typedef struct packed {
		logic occupied;
		logic tail;
	} cell_pos_t;

endpackage

// ===== rtl/spq_cell.sv =====
// one slot of the sorted row: holds an id and a priority
// depends on spq_pkg; shifts toward the tail on insert, toward the head on serve
module spq_cell
	import spq_pkg::*;
(
	input  logic                     clk,
	input  cell_cmd_t                cmd,
	input  cell_pos_t                pos,
	// neighbor toward the head
	input  logic                     prev_lower,
	input  logic [ID_BITS-1:0]       prev_id,
	input  logic [PRIORITY_BITS-1:0] prev_prio,
	// neighbor toward the tail
	input  logic [ID_BITS-1:0]       next_id,
	input  logic [PRIORITY_BITS-1:0] next_prio,
	output logic                     lower,
	output logic [ID_BITS-1:0]       id,
	output logic [PRIORITY_BITS-1:0] prio
);

	logic [ID_BITS-1:0]       id_q;
	logic [PRIORITY_BITS-1:0] prio_q;

	// stored entry ranks below the new one, so it moves back
	assign lower = pos.occupied && (prio_q < cmd.prio);
	assign id    = id_q;
	assign prio  = prio_q;

	// slot update: shift in from head side, take new entry, or shift from tail side
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (prev_lower) begin
				id_q   <= prev_id;
				prio_q <= prev_prio;
			end else if (lower || pos.tail) begin
				id_q   <= cmd.id;
				prio_q <= cmd.prio;
			end
		end else if (cmd.serve) begin
			id_q   <= next_id;
			prio_q <= next_prio;
		end
	end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue: a row of CAPACITY slots kept in descending priority,
// equal priorities first in, first out. One transaction (insert or serve) is
// taken per clock while the output register is free or draining; its result
// is loaded into the output register in the cycle after it is taken, and a
// new one is taken in the same cycle the previous result is taken. Every slot
// compares with the new entry in parallel and the row shifts by one slot at
// once. Reset clears only the count and valid flag; the queue is usable at once.
// depends on spq_pkg and spq_cell
module sorted_priority_queue
	import spq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// [15:0] item_id, [23:16] priority_req
	input  logic [IN_DATA_BITS-1:0]  s_tdata,
	// [0] mode
	input  logic                     s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// [15:0] served_id, [23:16] served_priority, [27:24] occupancy
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	// [1:0] status
	output logic [1:0]               m_tuser
);

	logic [CNT_BITS-1:0]      count_q;
	logic [CNT_BITS-1:0]      count_nxt;
	logic [CNT_BITS+OCC_BITS-1:0] count_ext;
	logic                     m_valid_q;
	status_t                  status_q;
	logic [ID_BITS-1:0]       sid_q;
	logic [PRIORITY_BITS-1:0] sprio_q;
	logic [OCC_BITS-1:0]      occ_q;

	logic      accept;
	mode_t     mode;
	logic      full;
	logic      empty;
	cell_cmd_t cmd;
	status_t   status_nxt;

	logic [CAPACITY-1:0]      lower;
	logic [ID_BITS-1:0]       ids   [CAPACITY];
	logic [PRIORITY_BITS-1:0] prios [CAPACITY];

	// input side accepts whenever the output register is free or draining
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign mode     = mode_t'(s_tuser);
	assign full     = (count_q == CNT_BITS'(CAPACITY));
	assign empty    = (count_q == '0);

	// command for the row
	assign cmd.insert = accept && (mode == MODE_INSERT) && !full;
	assign cmd.serve  = accept && (mode == MODE_SERVE) && !empty;
	assign cmd.id     = s_tdata[ID_BITS-1:0];
	assign cmd.prio   = s_tdata[ID_BITS+PRIORITY_BITS-1:ID_BITS];

	// row of cells
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		cell_pos_t pos;
		assign pos.occupied = (CNT_BITS'(k) < count_q);
		assign pos.tail     = (CNT_BITS'(k) == count_q);

		if (k == 0) begin : g_head
			if (CAPACITY > 1) begin : g_more
				spq_cell u_cell (
					.clk        (clk),
					.cmd        (cmd),
					.pos        (pos),
					.prev_lower (1'b0),
					.prev_id    ('0),
					.prev_prio  ('0),
					.next_id    (ids[k+1]),
					.next_prio  (prios[k+1]),
					.lower      (lower[k]),
					.id         (ids[k]),
					.prio       (prios[k])
				);
			end else begin : g_single
				spq_cell u_cell (
					.clk        (clk),
					.cmd        (cmd),
					.pos        (pos),
					.prev_lower (1'b0),
					.prev_id    ('0),
					.prev_prio  ('0),
					.next_id    ('0),
					.next_prio  ('0),
					.lower      (lower[k]),
					.id         (ids[k]),
					.prio       (prios[k])
				);
			end
		end else if (k == CAPACITY - 1) begin : g_tail
			spq_cell u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.pos        (pos),
				.prev_lower (lower[k-1]),
				.prev_id    (ids[k-1]),
				.prev_prio  (prios[k-1]),
				.next_id    ('0),
				.next_prio  ('0),
				.lower      (lower[k]),
				.id         (ids[k]),
				.prio       (prios[k])
			);
		end else begin : g_mid
			spq_cell u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.pos        (pos),
				.prev_lower (lower[k-1]),
				.prev_id    (ids[k-1]),
				.prev_prio  (prios[k-1]),
				.next_id    (ids[k+1]),
				.next_prio  (prios[k+1]),
				.lower      (lower[k]),
				.id         (ids[k]),
				.prio       (prios[k])
			);
		end
	end

	// fill level and status of this transaction
	always_comb begin
		count_nxt = count_q;
		if (cmd.insert) begin
			count_nxt = count_q + CNT_BITS'(1);
		end else if (cmd.serve) begin
			count_nxt = count_q - CNT_BITS'(1);
		end
		case (mode)
			MODE_INSERT: status_nxt = full ? ST_OVERFLOW : ST_DONE;
			MODE_SERVE:  status_nxt = empty ? ST_EMPTY : ST_DONE;
			default:     status_nxt = ST_DONE;
		endcase
	end

	assign count_ext = {{OCC_BITS{1'b0}}, count_nxt};

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
			sid_q    <= cmd.serve ? ids[0] : '0;
			sprio_q  <= cmd.serve ? prios[0] : '0;
			occ_q    <= count_ext[OCC_BITS-1:0];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {{(OUT_DATA_BITS-ID_BITS-PRIORITY_BITS-OCC_BITS){1'b0}},
		occ_q, sprio_q, sid_q};

endmodule

// ===== rtl/spq_checker.sv =====
// port-level checks of the sorted priority queue, bound to the top level
// depends on spq_pkg and assert_macros.svh
`include "assert_macros.svh"

module spq_checker
	import spq_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [OUT_DATA_BITS-1:0] m_tdata,
	input logic [1:0]               m_tuser
);

	localparam logic [OCC_BITS-1:0] OCC_FULL = OCC_BITS'(CAPACITY);

	// a stalled result holds
	`ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// every accepted transaction gives a result in the next cycle
	`ASSERT_NEXT(a_result, s_tvalid && s_tready, m_tvalid, "no result after accepted transaction")

	// refused transactions carry no served entry
	`ASSERT_SAME(a_zero, m_tvalid && (m_tuser != ST_DONE), m_tdata[ID_BITS+PRIORITY_BITS-1:0] == '0, "served fields not zero on refusal")

	// empty status only with nothing stored
	`ASSERT_SAME(a_empty, m_tvalid && (m_tuser == ST_EMPTY), m_tdata[ID_BITS+PRIORITY_BITS+OCC_BITS-1:ID_BITS+PRIORITY_BITS] == '0, "empty status with entries stored")

	// overflow status only with the queue full
	`ASSERT_SAME(a_full, m_tvalid && (m_tuser == ST_OVERFLOW), m_tdata[ID_BITS+PRIORITY_BITS+OCC_BITS-1:ID_BITS+PRIORITY_BITS] == OCC_FULL, "overflow status below capacity")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

// ===== dv/tb_sorted_priority_queue.sv =====
// testbench for the sorted priority queue: directed and random insert/serve traffic
// checked against an in-bench shadow of the sorted slot array
// depends on spq_pkg and the sorted_priority_queue rtl
module tb_sorted_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int RSP_BITS   = ID_BITS + PRIORITY_BITS + OCC_BITS;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		status_t                  status;
		logic [ID_BITS-1:0]       served_id;
		logic [PRIORITY_BITS-1:0] served_prio;
		logic [OCC_BITS-1:0]      occupancy;
	} queue_rsp_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	// [15:0] item_id, [23:16] priority_req
	logic [IN_DATA_BITS-1:0]  s_tdata;
	// [0] mode
	logic                     s_tuser;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	// [15:0] served_id, [23:16] served_priority, [27:24] occupancy
	logic [OUT_DATA_BITS-1:0] m_tdata;
	// [1:0] status
	logic [1:0]               m_tuser;

	// shadow copy of the slot row, slot 0 is the head
	logic [ID_BITS-1:0]       shadow_ids   [CAPACITY];
	logic [PRIORITY_BITS-1:0] shadow_prios [CAPACITY];
	int                       shadow_count;

	queue_rsp_t queued_responses[$];
	int         mismatch_count;
	int         stall_cycles;
	int         send_idle_pct;
	int         recv_idle_pct;

	sorted_priority_queue uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// apply one insert or serve to the shadow row and return its response
	function automatic queue_rsp_t apply_queue_op(input mode_t mode,
			input logic [ID_BITS-1:0] id, input logic [PRIORITY_BITS-1:0] prio);
		queue_rsp_t rsp;
		int         pos;
		rsp = '{status: ST_DONE, served_id: '0, served_prio: '0, occupancy: '0};
		if (mode == MODE_INSERT) begin
			if (shadow_count >= CAPACITY) begin
				rsp.status = ST_OVERFLOW;
			end else begin
				pos = shadow_count;
				// lower priorities move one slot toward the tail
				while (pos > 0 && shadow_prios[pos-1] < prio) begin
					shadow_ids[pos]   = shadow_ids[pos-1];
					shadow_prios[pos] = shadow_prios[pos-1];
					pos--;
				end
				shadow_ids[pos]   = id;
				shadow_prios[pos] = prio;
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				rsp.status = ST_EMPTY;
			end else begin
				rsp.served_id   = shadow_ids[0];
				rsp.served_prio = shadow_prios[0];
				for (int k = 0; k + 1 < shadow_count; k++) begin
					shadow_ids[k]   = shadow_ids[k+1];
					shadow_prios[k] = shadow_prios[k+1];
				end
				shadow_count--;
			end
		end
		rsp.occupancy = OCC_BITS'(shadow_count);
		return rsp;
	endfunction

	// drive one transaction at the falling edge and hold it until accepted
	task automatic issue_request(input mode_t mode, input logic [ID_BITS-1:0] id,
			input logic [PRIORITY_BITS-1:0] prio);
		logic [IN_DATA_BITS-1:0] word;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		word = '0;
		word[ID_BITS-1:0] = id;
		word[ID_BITS +: PRIORITY_BITS] = prio;
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tuser  <= mode;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		queued_responses.push_back(apply_queue_op(mode, id, prio));
		@(negedge clk);
	endtask

	task automatic serve_head();
		issue_request(MODE_SERVE, ID_BITS'($urandom), PRIORITY_BITS'($urandom));
	endtask

	// serve on an empty queue right after reset
	task automatic test_empty_serve();
		issue_request(MODE_SERVE, '1, '1);
	endtask

	// fill to capacity with extreme and tied priorities
	task automatic test_sorted_fill();
		issue_request(MODE_INSERT, 16'h0000, 8'h00);
		issue_request(MODE_INSERT, 16'hffff, 8'hff);
		issue_request(MODE_INSERT, 16'h00aa, 8'h80);
		issue_request(MODE_INSERT, 16'h00ab, 8'h80);
		issue_request(MODE_INSERT, 16'h5555, 8'h01);
		issue_request(MODE_INSERT, 16'h00ac, 8'h80);
		issue_request(MODE_INSERT, 16'haaaa, 8'hfe);
		issue_request(MODE_INSERT, 16'h0f0f, 8'h80);
	endtask

	// insert into a full queue, highest priority
	task automatic test_overflow();
		issue_request(MODE_INSERT, 16'h1111, 8'hff);
	endtask

	// drain in priority order, ties in arrival order, then one serve past empty
	task automatic test_drain();
		repeat (CAPACITY + 1)
			serve_head();
	endtask

	// bursts with varying insert bias and priority spread
	task automatic test_random_traffic(input int count);
		int sent;
		int burst_len;
		int insert_pct;
		int spread;
		logic [PRIORITY_BITS-1:0] base;
		logic [PRIORITY_BITS-1:0] prio;
		sent = 0;
		while (sent < count) begin
			burst_len = $urandom_range(24, 1);
			case ($urandom_range(2))
				0: insert_pct = 12;
				1: insert_pct = 50;
				default: insert_pct = 88;
			endcase
			spread = $urandom_range(3);
			base   = PRIORITY_BITS'($urandom);
			repeat (burst_len) begin
				case (spread)
					0: prio = PRIORITY_BITS'($urandom_range(3));
					1: prio = PRIORITY_BITS'($urandom);
					2: prio = $urandom_range(1) ? '1 : '0;
					default: prio = base + PRIORITY_BITS'($urandom_range(7));
				endcase
				if ($urandom_range(99) < insert_pct)
					issue_request(MODE_INSERT, ID_BITS'($urandom), prio);
				else
					serve_head();
				sent++;
			end
		end
	endtask

	// receiver back-pressure
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	// compare each response with the oldest prediction
	always @(posedge clk) begin : check_responses
		queue_rsp_t want;
		queue_rsp_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{status: status_t'(m_tuser),
				served_id: m_tdata[ID_BITS-1:0],
				served_prio: m_tdata[ID_BITS +: PRIORITY_BITS],
				occupancy: m_tdata[ID_BITS+PRIORITY_BITS +: OCC_BITS]};
			if (queued_responses.size() == 0) begin
				$display("%0t: unexpected response status %0d id %h prio %h occ %0d",
					$time, m_tuser, got.served_id, got.served_prio, got.occupancy);
				mismatch_count++;
			end else begin
				want = queued_responses.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, m_tuser);
					mismatch_count++;
				end
				if (got.served_id !== want.served_id) begin
					$display("%0t: served_id expected %h actual %h",
						$time, want.served_id, got.served_id);
					mismatch_count++;
				end
				if (got.served_prio !== want.served_prio) begin
					$display("%0t: served_priority expected %h actual %h",
						$time, want.served_prio, got.served_prio);
					mismatch_count++;
				end
				if (got.occupancy !== want.occupancy) begin
					$display("%0t: occupancy expected %0d actual %0d",
						$time, want.occupancy, got.occupancy);
					mismatch_count++;
				end
				if (m_tdata[OUT_DATA_BITS-1:RSP_BITS] !== '0) begin
					$display("%0t: tdata padding expected 0 actual %h",
						$time, m_tdata[OUT_DATA_BITS-1:RSP_BITS]);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("tb_sorted_priority_queue: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = 1'b0;
		shadow_count   = 0;
		mismatch_count = 0;
		send_idle_pct  = 34;
		recv_idle_pct  = 88;
		for (int k = 0; k < CAPACITY; k++) begin
			shadow_ids[k]   = '0;
			shadow_prios[k] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_serve();
		test_sorted_fill();
		test_overflow();
		test_drain();
		test_random_traffic(700);

		send_idle_pct = 88;
		recv_idle_pct = 34;
		test_random_traffic(650);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(650);

		s_tvalid <= 1'b0;
		while (queued_responses.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_sorted_priority_queue: PASS");
		else
			$display("tb_sorted_priority_queue: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
dv/tb_sorted_priority_queue.sv
